[rtl/core/mpfb_pkg.sv]
package mpfb_pkg;

  // Command codes on the command input.
  localparam logic [2:0] CMD_POINT      = 3'd0;
  localparam logic [2:0] CMD_FILL       = 3'd1;
  localparam logic [2:0] CMD_BLIT_BEGIN = 3'd2;
  localparam logic [2:0] CMD_BLIT_BYTE  = 3'd3;
  localparam logic [2:0] CMD_READ       = 3'd4;

  // Pen modes; any other code clears the pixel.
  localparam logic [1:0] PEN_SET    = 2'd1;
  localparam logic [1:0] PEN_INVERT = 2'd2;

  // Work classes handed from the front end to the back end.
  typedef enum logic [2:0] {
    OP_NONE,
    OP_POINT,
    OP_FILL,
    OP_BLIT,
    OP_READ
  } op_kind_e;

  // One queued operation. For a blit, row is the first row and nbits the row count.
  typedef struct packed {
    op_kind_e   kind;
    logic [7:0] col;
    logic [7:0] row;
    logic [3:0] nbits;
    logic [7:0] data;
    logic [1:0] pen;
    logic       done;
    logic       misuse;
  } op_t;

endpackage

[rtl/core/mpfb_front.sv]
module mpfb_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic [2:0]       command_i,
  input  logic [7:0]       x_pos_i,
  input  logic [7:0]       y_pos_i,
  input  logic [1:0]       pen_i,
  input  logic [7:0]       data_byte_i,
  input  logic [7:0]       extent_columns_i,
  input  logic [7:0]       extent_rows_i,
  output logic             push_o,
  output mpfb_pkg::op_t    op_o
);
  import mpfb_pkg::*;

  logic [7:0] origin_col_q, origin_col_d;
  logic [7:0] origin_row_q, origin_row_d;
  logic [7:0] blit_cols_q, blit_cols_d;
  logic [7:0] blit_rows_q, blit_rows_d;
  logic [7:0] cursor_col_q, cursor_col_d;
  logic [7:0] cursor_row_q, cursor_row_d;
  logic       active_q, active_d;

  logic [7:0] rows_left;
  logic [3:0] nbits;
  logic [8:0] row_next;
  logic       col_end;
  logic [7:0] col_next;
  logic       blit_fin;

  // Rows covered by the next blit byte and where the cursor goes after it.
  always_comb begin
    rows_left = blit_rows_q - cursor_row_q;
    nbits     = (rows_left >= 8'd8) ? 4'd8 : rows_left[3:0];
    row_next  = {1'b0, cursor_row_q} + 9'(nbits);
    col_end   = row_next >= {1'b0, blit_rows_q};
    col_next  = cursor_col_q + 8'd1;
    blit_fin  = col_end && ((col_next >= blit_cols_q) || (col_next == 8'd0));
  end

  // Decode the transaction into a queued operation and update the blit state.
  always_comb begin
    origin_col_d = origin_col_q;
    origin_row_d = origin_row_q;
    blit_cols_d  = blit_cols_q;
    blit_rows_d  = blit_rows_q;
    cursor_col_d = cursor_col_q;
    cursor_row_d = cursor_row_q;
    active_d     = active_q;
    op_o         = '0;
    op_o.kind    = OP_NONE;
    op_o.col     = x_pos_i;
    op_o.row     = y_pos_i;
    op_o.nbits   = 4'd1;
    op_o.data    = data_byte_i;
    op_o.pen     = pen_i;
    unique case (command_i)
      CMD_POINT: begin
        op_o.kind = OP_POINT;
      end
      CMD_FILL: begin
        op_o.kind = OP_FILL;
      end
      CMD_BLIT_BEGIN: begin
        if (accept_i) begin
          origin_col_d = x_pos_i;
          origin_row_d = y_pos_i;
          blit_cols_d  = extent_columns_i;
          blit_rows_d  = extent_rows_i;
          cursor_col_d = '0;
          cursor_row_d = '0;
          active_d     = (extent_columns_i != 8'd0) && (extent_rows_i != 8'd0);
        end
      end
      CMD_BLIT_BYTE: begin
        if (!active_q) begin
          op_o.misuse = 1'b1;
        end else begin
          op_o.kind  = OP_BLIT;
          op_o.col   = origin_col_q + cursor_col_q;
          op_o.row   = origin_row_q + cursor_row_q;
          op_o.nbits = nbits;
          op_o.done  = blit_fin;
          if (accept_i) begin
            if (col_end) begin
              cursor_row_d = '0;
              cursor_col_d = col_next;
              if (blit_fin) begin
                active_d = 1'b0;
              end
            end else begin
              cursor_row_d = row_next[7:0];
            end
          end
        end
      end
      CMD_READ: begin
        op_o.kind = OP_READ;
      end
      default: begin
        op_o.kind = OP_NONE;
      end
    endcase
  end

  assign push_o = accept_i;

  // Blit state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_col_q <= '0;
      origin_row_q <= '0;
      blit_cols_q  <= '0;
      blit_rows_q  <= '0;
      cursor_col_q <= '0;
      cursor_row_q <= '0;
      active_q     <= 1'b0;
    end else begin
      origin_col_q <= origin_col_d;
      origin_row_q <= origin_row_d;
      blit_cols_q  <= blit_cols_d;
      blit_rows_q  <= blit_rows_d;
      cursor_col_q <= cursor_col_d;
      cursor_row_q <= cursor_row_d;
      active_q     <= active_d;
    end
  end

endmodule

[rtl/core/mpfb_queue.sv]
module mpfb_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  mpfb_pkg::op_t  op_i,
  input  logic           pop_i,
  output logic           valid_o,
  output logic           full_o,
  output mpfb_pkg::op_t  op_o
);
  import mpfb_pkg::*;

  op_t        slot_q [2];
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  logic [1:0] count_q;

  assign valid_o = count_q != 2'd0;
  assign full_o  = count_q == 2'd2;
  assign op_o    = slot_q[rd_ptr_q];

  // Two-entry queue storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= op_i;
    end
  end

  // Queue pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 2'd1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

endmodule

[rtl/core/mpfb_back.sv]
module mpfb_back #(
  parameter int SCREEN_COLUMNS = 128,
  parameter int SCREEN_ROWS    = 64
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  input  mpfb_pkg::op_t  op_i,
  output logic           pop_o,
  output logic           clearing_o,
  output logic           result_valid_o,
  output logic [7:0]     read_data_o,
  output logic           blit_done_o,
  output logic           misuse_o
);
  import mpfb_pkg::*;

  localparam int PAGES = (SCREEN_ROWS + 7) / 8;
  localparam int DEPTH = PAGES * SCREEN_COLUMNS;
  localparam int AW    = $clog2(DEPTH);
  localparam logic [8:0] COLS9  = 9'(SCREEN_COLUMNS);
  localparam logic [8:0] ROWS9  = 9'(SCREEN_ROWS);
  localparam logic [8:0] PAGES9 = 9'(PAGES);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_FILL,
    S_RD,
    S_WR
  } state_e;

  state_e      state_q;
  op_t         op_q;
  logic [4:0]  page_q;
  logic        second_q;
  logic [AW-1:0] sweep_q;
  logic [7:0]  mem_q [DEPTH];
  logic [7:0]  rdata_q;

  logic          addr_ok;
  logic [13:0]   addr_full;
  logic [AW-1:0] addr;
  logic [7:0]    mask;
  logic [7:0]    val;
  logic [7:0]    py;
  logic [7:0]    row_last;
  logic [7:0]    new_byte;
  logic          we;
  logic [AW-1:0] waddr;
  logic [7:0]    wdata;

  // Store address of the current column and page, with clipping.
  always_comb begin
    addr_ok   = ({1'b0, op_q.col} < COLS9) && ({4'b0, page_q} < PAGES9);
    addr_full = 14'(page_q) * 14'(SCREEN_COLUMNS) + 14'(op_q.col);
    addr      = addr_full[AW-1:0];
    row_last  = op_q.row + 8'(op_q.nbits) - 8'd1;
  end

  // Bits of the current page touched by the operation, and their new values.
  always_comb begin
    mask = '0;
    val  = '0;
    py   = '0;
    for (int t = 0; t < 8; t++) begin
      py = op_q.row + 8'(t);
      if ((4'(t) < op_q.nbits) && (py[7:3] == page_q) && ({1'b0, py} < ROWS9)) begin
        mask[py[2:0]] = 1'b1;
        val[py[2:0]]  = op_q.data[7 - t];
      end
    end
    if (op_q.kind == OP_POINT) begin
      if (op_q.pen == PEN_SET) begin
        new_byte = rdata_q | mask;
      end else if (op_q.pen == PEN_INVERT) begin
        new_byte = rdata_q ^ mask;
      end else begin
        new_byte = rdata_q & ~mask;
      end
    end else begin
      new_byte = (rdata_q & ~mask) | (val & mask);
    end
  end

  // Store write port selection.
  always_comb begin
    we    = 1'b0;
    waddr = addr;
    wdata = new_byte;
    unique case (state_q)
      S_CLEAR: begin
        we    = 1'b1;
        waddr = sweep_q;
        wdata = '0;
      end
      S_FILL: begin
        we    = 1'b1;
        waddr = sweep_q;
        wdata = op_q.data;
      end
      S_WR: begin
        we = addr_ok && ((op_q.kind == OP_POINT) || (op_q.kind == OP_BLIT));
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  // Display store with a registered read port.
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    rdata_q <= mem_q[addr];
  end

  assign pop_o      = (state_q == S_IDLE) && valid_i;
  assign clearing_o = state_q == S_CLEAR;

  // Sequencer for clearing, fills and read-modify-write passes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_CLEAR;
      op_q           <= '0;
      page_q         <= '0;
      second_q       <= 1'b0;
      sweep_q        <= '0;
      result_valid_o <= 1'b0;
      read_data_o    <= '0;
      blit_done_o    <= 1'b0;
      misuse_o       <= 1'b0;
    end else begin
      result_valid_o <= 1'b0;
      unique case (state_q)
        S_CLEAR: begin
          sweep_q <= sweep_q + AW'(1);
          if (sweep_q == LAST) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (valid_i) begin
            op_q     <= op_i;
            page_q   <= op_i.row[7:3];
            second_q <= 1'b0;
            sweep_q  <= '0;
            unique case (op_i.kind)
              OP_FILL: state_q <= S_FILL;
              OP_POINT, OP_BLIT, OP_READ: state_q <= S_RD;
              default: begin
                result_valid_o <= 1'b1;
                read_data_o    <= '0;
                blit_done_o    <= op_i.done;
                misuse_o       <= op_i.misuse;
              end
            endcase
          end
        end
        S_FILL: begin
          sweep_q <= sweep_q + AW'(1);
          if (sweep_q == LAST) begin
            state_q        <= S_IDLE;
            result_valid_o <= 1'b1;
            read_data_o    <= '0;
            blit_done_o    <= 1'b0;
            misuse_o       <= 1'b0;
          end
        end
        S_RD: begin
          state_q <= S_WR;
        end
        S_WR: begin
          if ((op_q.kind == OP_BLIT) && !second_q && (row_last[7:3] != page_q)) begin
            page_q   <= row_last[7:3];
            second_q <= 1'b1;
            state_q  <= S_RD;
          end else begin
            state_q        <= S_IDLE;
            result_valid_o <= 1'b1;
            read_data_o    <= ((op_q.kind == OP_READ) && addr_ok) ? rdata_q : 8'd0;
            blit_done_o    <= op_q.done;
            misuse_o       <= op_q.misuse;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[rtl/core/mono_page_framebuffer_blitter.sv]
// A point, read or blit byte makes a store read pass then a write pass; a blit byte
// touching two store pages makes a second pass. A fill sweeps the whole store. Others,
// misused blit bytes among them, answer from the idle state. A two-entry queue takes
// new commands while the back end works; busy is high while the queue is full.
// Reset: asynchronous, active low; busy then stays high while all PAGES*SCREEN_COLUMNS
// bytes are cleared (1024 by default). Each result strobes once; no receiver stall.
module mono_page_framebuffer_blitter #(
  parameter int SCREEN_COLUMNS = 128,
  parameter int SCREEN_ROWS    = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  logic [2:0] command_i,
  input  logic [7:0] x_pos_i,
  input  logic [7:0] y_pos_i,
  input  logic [1:0] pen_i,
  input  logic [7:0] data_byte_i,
  input  logic [7:0] extent_columns_i,
  input  logic [7:0] extent_rows_i,
  output logic       result_valid_o,
  output logic [7:0] read_data_o,
  output logic       blit_done_o,
  output logic       misuse_o
);
  import mpfb_pkg::*;

  logic accept;
  logic push;
  op_t  push_op;
  logic pop;
  logic q_valid;
  logic q_full;
  op_t  q_op;
  logic clearing;

  assign busy   = q_full || clearing;
  assign accept = start && !busy;

  // Front end: decode and blit bookkeeping.
  mpfb_front u_front (
    .clk_i,
    .rst_ni,
    .accept_i         (accept),
    .command_i,
    .x_pos_i,
    .y_pos_i,
    .pen_i,
    .data_byte_i,
    .extent_columns_i,
    .extent_rows_i,
    .push_o           (push),
    .op_o             (push_op)
  );

  // Queue between the two halves.
  mpfb_queue u_queue (
    .clk_i,
    .rst_ni,
    .push_i  (push),
    .op_i    (push_op),
    .pop_i   (pop),
    .valid_o (q_valid),
    .full_o  (q_full),
    .op_o    (q_op)
  );

  // Back end: display store and its sequencer.
  mpfb_back #(
    .SCREEN_COLUMNS (SCREEN_COLUMNS),
    .SCREEN_ROWS    (SCREEN_ROWS)
  ) u_back (
    .clk_i,
    .rst_ni,
    .valid_i        (q_valid),
    .op_i           (q_op),
    .pop_o          (pop),
    .clearing_o     (clearing),
    .result_valid_o,
    .read_data_o,
    .blit_done_o,
    .misuse_o
  );

endmodule

[test/tb_mono_page_framebuffer_blitter.sv]
`timescale 1ns / 1ps

module tb_mono_page_framebuffer_blitter;
  import mpfb_pkg::*;

  localparam int COLS  = 128;
  localparam int ROWS  = 64;
  localparam int PAGES = (ROWS + 7) / 8;

  logic       clk_i;
  logic       rst_ni;
  logic       start;
  logic       busy;
  logic [2:0] command_i;
  logic [7:0] x_pos_i;
  logic [7:0] y_pos_i;
  logic [1:0] pen_i;
  logic [7:0] data_byte_i;
  logic [7:0] extent_columns_i;
  logic [7:0] extent_rows_i;
  logic       result_valid_o;
  logic [7:0] read_data_o;
  logic       blit_done_o;
  logic       misuse_o;

  mono_page_framebuffer_blitter uut (.*);

  // One command transaction and the response it should produce.
  typedef struct {
    logic [2:0] cmd;
    logic [7:0] x;
    logic [7:0] y;
    logic [1:0] pen;
    logic [7:0] data;
    logic [7:0] ecols;
    logic [7:0] erows;
  } command_t;

  typedef struct packed {
    logic [7:0] rdata;
    logic       done;
    logic       misuse;
  } response_t;

  // Directed rows: a known flag marks a response typed in by hand.
  typedef struct {
    command_t  c;
    bit        known;
    response_t r;
  } directed_row_t;

  // Shadow copy of the display store and blit state.
  logic [7:0] shadow_store [PAGES*COLS];
  logic [7:0] org_col, org_row, blit_cols, blit_rows, cur_col, cur_row;
  bit         blit_on;

  response_t pending_responses [$];
  int        error_count;
  int        response_count;
  int        blit_done_count;
  int        misuse_count;
  int        read_count;

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Safety net against a hung handshake.
  initial begin
    #20ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Apply one pixel update to the shadow store, clipped to the screen.
  function automatic void shadow_pixel(int px, int py, logic [1:0] mode);
    int         addr;
    logic [7:0] mask;
    if (px >= COLS || py >= ROWS) return;
    addr = (py / 8) * COLS + px;
    mask = 8'(1 << (py % 8));
    if (mode == PEN_SET) shadow_store[addr] |= mask;
    else if (mode == PEN_INVERT) shadow_store[addr] ^= mask;
    else shadow_store[addr] &= ~mask;
  endfunction

  // Work out the response of one command and advance the shadow state.
  function automatic response_t predict_framebuffer(command_t c);
    response_t  r;
    int         row;
    int         px;
    logic [7:0] bits;
    r = '{8'd0, 1'b0, 1'b0};
    case (c.cmd)
      CMD_POINT: shadow_pixel(c.x, c.y, c.pen);
      CMD_FILL: foreach (shadow_store[i]) shadow_store[i] = c.data;
      CMD_BLIT_BEGIN: begin
        org_col = c.x; org_row = c.y;
        blit_cols = c.ecols; blit_rows = c.erows;
        cur_col = 0; cur_row = 0;
        blit_on = (c.ecols != 0 && c.erows != 0);
      end
      CMD_BLIT_BYTE: begin
        if (!blit_on) begin
          r.misuse = 1'b1;
        end else begin
          bits = c.data;
          row = cur_row;
          px = (org_col + cur_col) & 8'hff;
          for (int t = 0; t < 8; t++) begin
            shadow_pixel(px, (org_row + row) & 8'hff, bits[7] ? PEN_SET : 2'd0);
            bits = bits << 1;
            row++;
            if (row >= blit_rows) break;
          end
          if (row >= blit_rows) begin
            cur_row = 0;
            cur_col = cur_col + 8'd1;
            if (cur_col >= blit_cols || cur_col == 0) begin
              blit_on = 1'b0;
              r.done = 1'b1;
            end
          end else begin
            cur_row = 8'(row);
          end
        end
      end
      CMD_READ: begin
        if (c.x < COLS && (c.y >> 3) < PAGES) r.rdata = shadow_store[(c.y >> 3) * COLS + c.x];
      end
      default: ;
    endcase
    return r;
  endfunction

  // Drive one command at a falling edge and hold it until accepted.
  // The task returns at the falling edge after acceptance with start still high.
  task automatic issue_command(command_t c);
    int gap;
    gap = $urandom_range(0, 9);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    command_i        <= c.cmd;
    x_pos_i          <= c.x;
    y_pos_i          <= c.y;
    pen_i            <= c.pen;
    data_byte_i      <= c.data;
    extent_columns_i <= c.ecols;
    extent_rows_i    <= c.erows;
    start            <= 1'b1;
    do @(posedge clk_i); while (busy);
    pending_responses.push_back(predict_framebuffer(c));
    @(negedge clk_i);
  endtask

  // Wait until every outstanding response has come back.
  task automatic drain_responses();
    start <= 1'b0;
    @(negedge clk_i);
    while (pending_responses.size() != 0) @(negedge clk_i);
  endtask

  // Check each response against the oldest expectation.
  always @(posedge clk_i) begin
    response_t e;
    if (rst_ni && result_valid_o) begin
      response_count++;
      if (blit_done_o) blit_done_count++;
      if (misuse_o) misuse_count++;
      if (pending_responses.size() == 0) begin
        $error("response with no transaction outstanding");
        error_count++;
      end else begin
        e = pending_responses.pop_front();
        if (read_data_o !== e.rdata) begin
          $error("read_data expected %0h actual %0h", e.rdata, read_data_o);
          error_count++;
        end
        if (blit_done_o !== e.done) begin
          $error("blit_done expected %0b actual %0b", e.done, blit_done_o);
          error_count++;
        end
        if (misuse_o !== e.misuse) begin
          $error("misuse expected %0b actual %0b", e.misuse, misuse_o);
          error_count++;
        end
      end
    end
  end

  function automatic command_t make_cmd(logic [2:0] cmd, logic [7:0] x, logic [7:0] y,
                                        logic [1:0] pen, logic [7:0] data,
                                        logic [7:0] ecols, logic [7:0] erows);
    command_t c;
    c = '{cmd, x, y, pen, data, ecols, erows};
    return c;
  endfunction

  function automatic command_t random_cmd(logic [2:0] cmd);
    return make_cmd(cmd, 8'($urandom), 8'($urandom), 2'($urandom), 8'($urandom),
                    8'($urandom), 8'($urandom));
  endfunction

  // Random blit, mostly small and often on or near the screen, fed to completion (sometimes cut short).
  task automatic random_blit();
    command_t c;
    int       ncols, nrows, nbytes;
    ncols = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 255) : $urandom_range(1, 6);
    nrows = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 255) : $urandom_range(1, 20);
    if ($urandom_range(0, 1)) begin
      c = make_cmd(CMD_BLIT_BEGIN, 8'($urandom_range(0, COLS + 4)),
                   8'($urandom_range(0, ROWS + 4)), 2'($urandom), 8'($urandom),
                   8'(ncols), 8'(nrows));
    end else begin
      c = random_cmd(CMD_BLIT_BEGIN);
      c.ecols = 8'(ncols); c.erows = 8'(nrows);
    end
    issue_command(c);
    nbytes = ncols * ((nrows + 7) / 8);
    if (nbytes > 24) nbytes = $urandom_range(1, 24);
    if ($urandom_range(0, 7) == 0) nbytes = $urandom_range(0, nbytes);
    for (int i = 0; i < nbytes; i++) begin
      if ($urandom_range(0, 9) == 0) issue_command(random_cmd(CMD_POINT));
      issue_command(random_cmd(CMD_BLIT_BYTE));
    end
  endtask

  initial begin
    directed_row_t rows [$];
    command_t      c;
    int            items;
    int            pick;

    error_count = 0;
    response_count = 0;
    blit_done_count = 0;
    misuse_count = 0;
    read_count = 0;
    foreach (shadow_store[i]) shadow_store[i] = 8'd0;
    org_col = 0; org_row = 0; blit_cols = 0; blit_rows = 0;
    cur_col = 0; cur_row = 0; blit_on = 1'b0;

    rst_ni = 1'b0;
    start = 1'b0;
    command_i = CMD_POINT;
    x_pos_i = '0; y_pos_i = '0; pen_i = '0; data_byte_i = '0;
    extent_columns_i = '0; extent_rows_i = '0;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed table: reset contents, extremes, pens, blits and misuse.
    rows = '{
      '{make_cmd(CMD_READ, 8'd0, 8'd0, 2'd0, 8'd0, 8'd0, 8'd0), 1, '{8'h00, 0, 0}},
      '{make_cmd(CMD_READ, 8'd127, 8'd63, 2'd0, 8'd0, 8'd0, 8'd0), 1, '{8'h00, 0, 0}},
      '{make_cmd(CMD_BLIT_BYTE, 8'd0, 8'd0, 2'd0, 8'hff, 8'd0, 8'd0), 1, '{8'h00, 0, 1}},
      '{make_cmd(CMD_FILL, 8'd0, 8'd0, 2'd0, 8'hff, 8'd0, 8'd0), 1, '{8'h00, 0, 0}},
      '{make_cmd(CMD_READ, 8'd127, 8'd63, 2'd0, 8'd0, 8'd0, 8'd0), 1, '{8'hff, 0, 0}},
      '{make_cmd(CMD_READ, 8'd128, 8'd0, 2'd0, 8'd0, 8'd0, 8'd0), 1, '{8'h00, 0, 0}},
      '{make_cmd(CMD_READ, 8'd0, 8'd64, 2'd0, 8'd0, 8'd0, 8'd0), 1, '{8'h00, 0, 0}},
      '{make_cmd(CMD_READ, 8'd255, 8'd255, 2'd3, 8'hff, 8'hff, 8'hff), 1, '{8'h00, 0, 0}},
      '{make_cmd(CMD_FILL, 8'hff, 8'hff, 2'd3, 8'h00, 8'hff, 8'hff), 1, '{8'h00, 0, 0}},
      '{make_cmd(CMD_POINT, 8'd0, 8'd0, PEN_SET, 8'd0, 8'd0, 8'd0), 0, '{8'h00, 0, 0}},
      '{make_cmd(CMD_POINT, 8'd127, 8'd63, PEN_INVERT, 8'd0, 8'd0, 8'd0), 0, '{8'h00, 0, 0}},
      '{make_cmd(CMD_POINT, 8'd0, 8'd0, 2'd3, 8'd0, 8'd0, 8'd0), 0, '{8'h00, 0, 0}},
      '{make_cmd(CMD_POINT, 8'd200, 8'd5, PEN_SET, 8'd0, 8'd0, 8'd0), 0, '{8'h00, 0, 0}},
      '{make_cmd(CMD_POINT, 8'd5, 8'd70, PEN_SET, 8'd0, 8'd0, 8'd0), 0, '{8'h00, 0, 0}},
      '{make_cmd(CMD_READ, 8'd127, 8'd56, 2'd0, 8'd0, 8'd0, 8'd0), 1, '{8'h80, 0, 0}},
      '{make_cmd(CMD_BLIT_BEGIN, 8'd10, 8'd4, 2'd0, 8'd0, 8'd0, 8'd5), 0, '{8'h00, 0, 0}},
      '{make_cmd(CMD_BLIT_BYTE, 8'd0, 8'd0, 2'd0, 8'hff, 8'd0, 8'd0), 1, '{8'h00, 0, 1}},
      '{make_cmd(CMD_BLIT_BEGIN, 8'd254, 8'd250, 2'd0, 8'd0, 8'd3, 8'd12), 0, '{8'h00, 0, 0}},
      '{make_cmd(CMD_BLIT_BYTE, 8'd0, 8'd0, 2'd0, 8'hff, 8'd0, 8'd0), 0, '{8'h00, 0, 0}},
      '{make_cmd(CMD_BLIT_BEGIN, 8'd120, 8'd60, 2'd0, 8'd0, 8'd2, 8'd3), 0, '{8'h00, 0, 0}},
      '{make_cmd(CMD_BLIT_BYTE, 8'd0, 8'd0, 2'd0, 8'hbf, 8'd0, 8'd0), 0, '{8'h00, 0, 0}},
      '{make_cmd(CMD_READ, 8'd120, 8'd60, 2'd0, 8'd0, 8'd0, 8'd0), 0, '{8'h00, 0, 0}},
      '{make_cmd(CMD_BLIT_BYTE, 8'd0, 8'd0, 2'd0, 8'h40, 8'd0, 8'd0), 0, '{8'h00, 0, 0}},
      '{make_cmd(CMD_READ, 8'd121, 8'd60, 2'd0, 8'd0, 8'd0, 8'd0), 0, '{8'h00, 0, 0}},
      '{make_cmd(3'd7, 8'hff, 8'hff, 2'd3, 8'hff, 8'hff, 8'hff), 1, '{8'h00, 0, 0}}
    };
    foreach (rows[i]) begin
      issue_command(rows[i].c);
      if (rows[i].known &&
          pending_responses[$] != rows[i].r) begin
        $error("directed row %0d: hand value %p disagrees with prediction %p",
               i, rows[i].r, pending_responses[$]);
        error_count++;
      end
    end

    // Hold the sender off until the block has answered everything.
    drain_responses();

    // Random part: mostly well-formed blits, plus points, reads, fills and noise.
    items = 0;
    while (items < 700) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        random_blit();
        items += 8;
      end else if (pick < 55) begin
        c = random_cmd(CMD_POINT);
        if ($urandom_range(0, 3) != 0) begin
          c.x = 8'($urandom_range(0, COLS - 1)); c.y = 8'($urandom_range(0, ROWS - 1));
        end
        issue_command(c);
        items++;
      end else if (pick < 85) begin
        c = random_cmd(CMD_READ);
        if ($urandom_range(0, 3) != 0) begin
          c.x = 8'($urandom_range(0, COLS - 1)); c.y = 8'($urandom_range(0, ROWS - 1));
        end
        issue_command(c);
        read_count++;
        items++;
      end else if (pick < 87) begin
        issue_command(random_cmd(CMD_FILL));
        items++;
      end else if (pick < 95) begin
        issue_command(random_cmd(CMD_BLIT_BYTE));
        items++;
      end else begin
        issue_command(random_cmd(3'($urandom_range(5, 7))));
        items++;
      end
      if (pick == 99) drain_responses();
    end

    // Let the block settle, then report.
    drain_responses();
    repeat (50) @(negedge clk_i);
    $display("Run covered %0d responses: %0d random reads, %0d blits completed, %0d misuse.",
             response_count, read_count, blit_done_count, misuse_count);
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
